// ----- rtl/pcss_pkg.sv -----
package pcss_pkg;

    localparam int CELL_COUNT   = 4096;
    localparam int CELL_AW      = 12;
    localparam int VALUE_W      = 32;
    localparam int CODE_W       = 12;
    localparam int COUNT_W      = 13;
    localparam int HASH_SLOTS   = 2 * CELL_COUNT;
    localparam int HASH_AW      = 13;
    localparam int HASH_W       = 1 + CODE_W + VALUE_W;
    localparam int COST_W       = 17;
    localparam int PAYLOAD_W    = 15;
    localparam int DIRECT_BYTES = CELL_COUNT * 4;
    localparam int UNIFORM_BYTES = 4;
    localparam int INDEX_BYTES_PER_BIT = (CELL_COUNT / 64) * 8;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;

    typedef enum logic [1:0] {
        MODE_UNIFORM = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_DIRECT  = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FETCH_PAL,
        ST_DECIDE,
        ST_U_SET,
        ST_U_CLR,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_CPY_IDX,
        ST_CPY_PAL,
        ST_CPY_WR,
        ST_MKDIR_WR,
        ST_COUNT,
        ST_HCLR,
        ST_SC_RD,
        ST_SC_HASH,
        ST_SC_PROBE,
        ST_SC_END,
        ST_DONE
    } state_t;

    // Smallest b >= 1 with 2^b >= n.
    function automatic logic [3:0] bits_for(input logic [COUNT_W-1:0] n);
        logic [3:0] b;
        b = 4'd1;
        for (int k = 1; k < COUNT_W; k++) begin
            if (n > (COUNT_W'(1) << k)) begin
                b = 4'(k + 1);
            end
        end
        return b;
    endfunction

    // Packed palette cost in bytes for n entries.
    function automatic logic [COST_W-1:0] packed_cost(input logic [COUNT_W-1:0] n);
        logic [COST_W-1:0] c;
        c = (COST_W'(n) << 2) + COST_W'(bits_for(n)) * COST_W'(INDEX_BYTES_PER_BIT);
        return c;
    endfunction

    function automatic logic [HASH_AW-1:0] hash_of(input logic [VALUE_W-1:0] v);
        return v[12:0] ^ v[25:13] ^ {7'd0, v[31:26]};
    endfunction

endpackage

// ----- rtl/pcss_ram.sv -----
module pcss_ram #(
    parameter int WIDTH = pcss_pkg::VALUE_W,
    parameter int DEPTH = pcss_pkg::CELL_COUNT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/palette_compressed_section_store.sv -----
// Palette-compressed store of 4096 cells of 32-bit values, kept in uniform, palette or
// direct mode. Each input beat is a read, a write or a fill request and produces exactly
// one output beat with the cell value after the request, the mode, the palette size and
// the payload cost in bytes. The block works on one request at a time; s_tready is high
// only while it waits for a request. A changed write in palette mode searches the palette
// memory one entry at a time, starting at entry 0. The first write that leaves uniform
// mode rewrites the whole index memory. A palette overflow copies every cell into the
// direct memory. Every writes_between_compactions counted writes the store is compacted:
// the cells are first copied into the direct memory (skipped in direct mode), an 8192-slot
// hash memory is cleared, and each cell is then looked up in the hash with linear probing
// until the palette would overflow, which leaves the store in direct mode. The compaction
// interval is written on cfg_wr_en/cfg_wr_data and must only be changed while the block
// is idle. No memory needs clearing after reset.
module palette_compressed_section_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] req_type, [13:2] cell_index, [45:14] cell_value, rest zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_value, [33:32] store_mode, [46:34] palette_size,
    // [61:47] payload_bytes, rest zero
    output logic [63:0] m_tdata
);

    localparam int AW  = pcss_pkg::CELL_AW;
    localparam int VW  = pcss_pkg::VALUE_W;
    localparam int CW  = pcss_pkg::COUNT_W;
    localparam int HAW = pcss_pkg::HASH_AW;
    localparam int HW  = pcss_pkg::HASH_W;
    localparam logic [AW-1:0]  LAST_CELL = AW'(pcss_pkg::CELL_COUNT - 1);
    localparam logic [HAW-1:0] LAST_SLOT = HAW'(pcss_pkg::HASH_SLOTS - 1);
    localparam logic [pcss_pkg::COST_W-1:0] FULL_COST =
        pcss_pkg::COST_W'(pcss_pkg::DIRECT_BYTES);

    pcss_pkg::state_t state_reg, state_next;
    pcss_pkg::mode_t  mode_reg, mode_next;

    logic [VW-1:0]  uni_reg, uni_next;
    logic [CW-1:0]  pcount_reg, pcount_next;
    logic [CW-1:0]  wcount_reg, wcount_next;
    logic [CW-1:0]  wbc_reg, wbc_next;
    logic [1:0]     req_reg, req_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [VW-1:0]  res_reg, res_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [AW-1:0]  p_reg, p_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [HAW-1:0] h_reg, h_next;
    logic [VW-1:0]  v_reg, v_next;
    logic [VW-1:0]  first_reg, first_next;
    logic           cpc_reg, cpc_next;
    logic           tod_reg, tod_next;
    logic           mvalid_reg, mvalid_next;
    logic [63:0]    mdata_reg, mdata_next;

    // Memory ports.
    logic           pal_we, idx_we, dir_we, hsh_we;
    logic [AW-1:0]  pal_waddr, idx_waddr, dir_waddr, pal_raddr, idx_raddr, dir_raddr;
    logic [VW-1:0]  pal_wdata, dir_wdata, pal_rdata, dir_rdata;
    logic [AW-1:0]  idx_wdata, idx_rdata;
    logic [HAW-1:0] hsh_waddr, hsh_raddr;
    logic [HW-1:0]  hsh_wdata, hsh_rdata;

    // Shared conditions.
    logic           s_accept;
    logic           out_load;
    logic [VW-1:0]  cur_val;
    logic [CW:0]    wc_sum;
    logic           compact_due;
    logic           grow_full;
    logic           scan_full;
    logic           cell_last;
    logic           srch_hit;
    logic           srch_more;
    logic           h_used;
    logic [AW-1:0]  h_code;
    logic [VW-1:0]  h_key;
    logic           probe_on;
    logic [pcss_pkg::COST_W-1:0]    pal_cost;
    logic [pcss_pkg::PAYLOAD_W-1:0] payload;
    logic [CW-1:0]  psize;

    pcss_ram #(.WIDTH(VW), .DEPTH(pcss_pkg::CELL_COUNT)) u_pal_ram (
        .aclk(aclk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
        .raddr(pal_raddr), .rdata(pal_rdata)
    );

    pcss_ram #(.WIDTH(AW), .DEPTH(pcss_pkg::CELL_COUNT)) u_idx_ram (
        .aclk(aclk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
        .raddr(idx_raddr), .rdata(idx_rdata)
    );

    pcss_ram #(.WIDTH(VW), .DEPTH(pcss_pkg::CELL_COUNT)) u_dir_ram (
        .aclk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rdata)
    );

    // Hash slots hold {used, code, key}; used during compaction only.
    pcss_ram #(.WIDTH(HW), .DEPTH(pcss_pkg::HASH_SLOTS)) u_hsh_ram (
        .aclk(aclk), .we(hsh_we), .waddr(hsh_waddr), .wdata(hsh_wdata),
        .raddr(hsh_raddr), .rdata(hsh_rdata)
    );

    assign s_tready = (state_reg == pcss_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // The value of the requested cell, valid in the decide state.
    always_comb begin
        case (mode_reg)
            pcss_pkg::MODE_DIRECT:  cur_val = dir_rdata;
            pcss_pkg::MODE_PALETTE: cur_val = pal_rdata;
            default:                cur_val = uni_reg;
        endcase
    end

    assign wc_sum      = {1'b0, wcount_reg} + (CW + 1)'(1);
    assign compact_due = (wc_sum >= {1'b0, wbc_reg});
    assign grow_full   = (pcss_pkg::packed_cost(pcount_reg + CW'(1)) >= FULL_COST);
    assign scan_full   = (pcss_pkg::packed_cost(n_reg + CW'(1)) >= FULL_COST);
    assign cell_last   = (i_reg[AW-1:0] == LAST_CELL);
    assign srch_hit    = (pal_rdata == val_reg);
    assign srch_more   = ({1'b0, p_reg} + CW'(1) < pcount_reg);
    assign h_used      = hsh_rdata[HW-1];
    assign h_code      = hsh_rdata[VW +: AW];
    assign h_key       = hsh_rdata[VW-1:0];
    assign probe_on    = h_used && (h_key != v_reg);
    assign pal_cost    = pcss_pkg::packed_cost(pcount_reg);

    // Cost and size as reported in each output beat.
    always_comb begin
        case (mode_reg)
            pcss_pkg::MODE_PALETTE: begin
                payload = pal_cost[pcss_pkg::PAYLOAD_W-1:0];
                psize   = pcount_reg;
            end
            pcss_pkg::MODE_DIRECT: begin
                payload = pcss_pkg::PAYLOAD_W'(pcss_pkg::DIRECT_BYTES);
                psize   = '0;
            end
            default: begin
                payload = pcss_pkg::PAYLOAD_W'(pcss_pkg::UNIFORM_BYTES);
                psize   = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcss_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tdata[1:0] == pcss_pkg::REQ_FILL) ?
                                 pcss_pkg::ST_DONE : pcss_pkg::ST_FETCH;
                end
            end
            pcss_pkg::ST_FETCH: begin
                state_next = (mode_reg == pcss_pkg::MODE_PALETTE) ?
                             pcss_pkg::ST_FETCH_PAL : pcss_pkg::ST_DECIDE;
            end
            pcss_pkg::ST_FETCH_PAL: state_next = pcss_pkg::ST_DECIDE;
            pcss_pkg::ST_DECIDE: begin
                if (req_reg != pcss_pkg::REQ_WRITE || cur_val == val_reg) begin
                    state_next = pcss_pkg::ST_DONE;
                end else begin
                    case (mode_reg)
                        pcss_pkg::MODE_UNIFORM: state_next = pcss_pkg::ST_U_SET;
                        pcss_pkg::MODE_PALETTE: state_next = pcss_pkg::ST_SRCH;
                        default:                state_next = pcss_pkg::ST_COUNT;
                    endcase
                end
            end
            pcss_pkg::ST_U_SET: state_next = pcss_pkg::ST_U_CLR;
            pcss_pkg::ST_U_CLR: begin
                if (cell_last) begin
                    state_next = pcss_pkg::ST_COUNT;
                end
            end
            pcss_pkg::ST_SRCH: state_next = pcss_pkg::ST_SRCH_CMP;
            pcss_pkg::ST_SRCH_CMP: begin
                if (srch_hit) begin
                    state_next = pcss_pkg::ST_COUNT;
                end else if (srch_more) begin
                    state_next = pcss_pkg::ST_SRCH;
                end else if (grow_full) begin
                    state_next = pcss_pkg::ST_CPY_IDX;
                end else begin
                    state_next = pcss_pkg::ST_COUNT;
                end
            end
            pcss_pkg::ST_CPY_IDX: state_next = pcss_pkg::ST_CPY_PAL;
            pcss_pkg::ST_CPY_PAL: state_next = pcss_pkg::ST_CPY_WR;
            pcss_pkg::ST_CPY_WR: begin
                if (!cell_last) begin
                    state_next = pcss_pkg::ST_CPY_IDX;
                end else if (cpc_reg) begin
                    state_next = pcss_pkg::ST_HCLR;
                end else begin
                    state_next = pcss_pkg::ST_MKDIR_WR;
                end
            end
            pcss_pkg::ST_MKDIR_WR: state_next = pcss_pkg::ST_COUNT;
            pcss_pkg::ST_COUNT: begin
                if (!compact_due) begin
                    state_next = pcss_pkg::ST_DONE;
                end else if (mode_reg == pcss_pkg::MODE_PALETTE) begin
                    state_next = pcss_pkg::ST_CPY_IDX;
                end else begin
                    state_next = pcss_pkg::ST_HCLR;
                end
            end
            pcss_pkg::ST_HCLR: begin
                if (i_reg[HAW-1:0] == LAST_SLOT) begin
                    state_next = pcss_pkg::ST_SC_RD;
                end
            end
            pcss_pkg::ST_SC_RD:   state_next = pcss_pkg::ST_SC_HASH;
            pcss_pkg::ST_SC_HASH: state_next = pcss_pkg::ST_SC_PROBE;
            pcss_pkg::ST_SC_PROBE: begin
                if (probe_on) begin
                    state_next = pcss_pkg::ST_SC_PROBE;
                end else if ((!h_used && scan_full) || cell_last) begin
                    state_next = pcss_pkg::ST_SC_END;
                end else begin
                    state_next = pcss_pkg::ST_SC_RD;
                end
            end
            pcss_pkg::ST_SC_END: state_next = pcss_pkg::ST_DONE;
            pcss_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = pcss_pkg::ST_IDLE;
                end
            end
            default: state_next = pcss_pkg::ST_IDLE;
        endcase
    end

    // Register updates and memory controls.
    always_comb begin
        mode_next   = mode_reg;
        uni_next    = uni_reg;
        pcount_next = pcount_reg;
        wcount_next = wcount_reg;
        wbc_next    = cfg_wr_en ? cfg_wr_data : wbc_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        h_next      = h_reg;
        v_next      = v_reg;
        first_next  = first_reg;
        cpc_next    = cpc_reg;
        tod_next    = tod_reg;
        mvalid_next = (mvalid_reg && m_tready) ? 1'b0 : mvalid_reg;
        mdata_next  = mdata_reg;

        pal_we = 1'b0; pal_waddr = '0; pal_wdata = '0; pal_raddr = '0;
        idx_we = 1'b0; idx_waddr = '0; idx_wdata = '0; idx_raddr = idx_reg;
        dir_we = 1'b0; dir_waddr = '0; dir_wdata = '0; dir_raddr = idx_reg;
        hsh_we = 1'b0; hsh_waddr = '0; hsh_wdata = '0; hsh_raddr = '0;

        case (state_reg)
            pcss_pkg::ST_IDLE: begin
                if (s_accept) begin
                    req_next = s_tdata[1:0];
                    idx_next = s_tdata[13:2];
                    val_next = s_tdata[45:14];
                    if (s_tdata[1:0] == pcss_pkg::REQ_FILL) begin
                        mode_next   = pcss_pkg::MODE_UNIFORM;
                        uni_next    = s_tdata[45:14];
                        pcount_next = '0;
                        wcount_next = '0;
                        res_next    = s_tdata[45:14];
                    end
                end
            end
            pcss_pkg::ST_FETCH_PAL: begin
                pal_raddr = idx_rdata;
            end
            pcss_pkg::ST_DECIDE: begin
                res_next = cur_val;
                if (req_reg == pcss_pkg::REQ_WRITE && cur_val != val_reg) begin
                    res_next = val_reg;
                    case (mode_reg)
                        pcss_pkg::MODE_UNIFORM: begin
                            pal_we    = 1'b1;
                            pal_waddr = '0;
                            pal_wdata = uni_reg;
                        end
                        pcss_pkg::MODE_PALETTE: begin
                            p_next = '0;
                        end
                        default: begin
                            dir_we    = 1'b1;
                            dir_waddr = idx_reg;
                            dir_wdata = val_reg;
                        end
                    endcase
                end
            end
            pcss_pkg::ST_U_SET: begin
                pal_we    = 1'b1;
                pal_waddr = AW'(1);
                pal_wdata = val_reg;
                i_next    = '0;
            end
            pcss_pkg::ST_U_CLR: begin
                // Every cell codes the old uniform value except the written one.
                idx_we    = 1'b1;
                idx_waddr = i_reg[AW-1:0];
                idx_wdata = (i_reg[AW-1:0] == idx_reg) ? AW'(1) : '0;
                i_next    = i_reg + CW'(1);
                if (cell_last) begin
                    mode_next   = pcss_pkg::MODE_PALETTE;
                    pcount_next = CW'(2);
                end
            end
            pcss_pkg::ST_SRCH: begin
                pal_raddr = p_reg;
            end
            pcss_pkg::ST_SRCH_CMP: begin
                if (srch_hit) begin
                    idx_we    = 1'b1;
                    idx_waddr = idx_reg;
                    idx_wdata = p_reg;
                end else if (srch_more) begin
                    p_next = p_reg + AW'(1);
                end else if (grow_full) begin
                    i_next   = '0;
                    cpc_next = 1'b0;
                end else begin
                    pal_we      = 1'b1;
                    pal_waddr   = pcount_reg[AW-1:0];
                    pal_wdata   = val_reg;
                    idx_we      = 1'b1;
                    idx_waddr   = idx_reg;
                    idx_wdata   = pcount_reg[AW-1:0];
                    pcount_next = pcount_reg + CW'(1);
                end
            end
            pcss_pkg::ST_CPY_IDX: begin
                idx_raddr = i_reg[AW-1:0];
            end
            pcss_pkg::ST_CPY_PAL: begin
                pal_raddr = idx_rdata;
            end
            pcss_pkg::ST_CPY_WR: begin
                dir_we    = 1'b1;
                dir_waddr = i_reg[AW-1:0];
                dir_wdata = pal_rdata;
                i_next    = cell_last ? '0 : i_reg + CW'(1);
            end
            pcss_pkg::ST_MKDIR_WR: begin
                dir_we      = 1'b1;
                dir_waddr   = idx_reg;
                dir_wdata   = val_reg;
                mode_next   = pcss_pkg::MODE_DIRECT;
                pcount_next = '0;
            end
            pcss_pkg::ST_COUNT: begin
                wcount_next = wc_sum[CW-1:0];
                if (compact_due) begin
                    i_next   = '0;
                    cpc_next = 1'b1;
                end
            end
            pcss_pkg::ST_HCLR: begin
                hsh_we    = 1'b1;
                hsh_waddr = i_reg[HAW-1:0];
                hsh_wdata = '0;
                i_next    = i_reg + CW'(1);
                if (i_reg[HAW-1:0] == LAST_SLOT) begin
                    i_next   = '0;
                    n_next   = '0;
                    tod_next = 1'b0;
                end
            end
            pcss_pkg::ST_SC_RD: begin
                dir_raddr = i_reg[AW-1:0];
            end
            pcss_pkg::ST_SC_HASH: begin
                v_next    = dir_rdata;
                h_next    = pcss_pkg::hash_of(dir_rdata);
                hsh_raddr = pcss_pkg::hash_of(dir_rdata);
                if (i_reg == '0) begin
                    first_next = dir_rdata;
                end
            end
            pcss_pkg::ST_SC_PROBE: begin
                if (probe_on) begin
                    // Linear probing; the index wraps at the end of the table.
                    h_next    = h_reg + HAW'(1);
                    hsh_raddr = h_reg + HAW'(1);
                end else begin
                    if (h_used) begin
                        idx_we    = 1'b1;
                        idx_waddr = i_reg[AW-1:0];
                        idx_wdata = h_code;
                    end else if (scan_full) begin
                        tod_next = 1'b1;
                    end else begin
                        hsh_we    = 1'b1;
                        hsh_waddr = h_reg;
                        hsh_wdata = {1'b1, n_reg[AW-1:0], v_reg};
                        pal_we    = 1'b1;
                        pal_waddr = n_reg[AW-1:0];
                        pal_wdata = v_reg;
                        idx_we    = 1'b1;
                        idx_waddr = i_reg[AW-1:0];
                        idx_wdata = n_reg[AW-1:0];
                        n_next    = n_reg + CW'(1);
                    end
                    i_next = i_reg + CW'(1);
                end
            end
            pcss_pkg::ST_SC_END: begin
                // The direct memory already holds every cell, so overflow needs no copy.
                wcount_next = '0;
                if (tod_reg) begin
                    mode_next   = pcss_pkg::MODE_DIRECT;
                    pcount_next = '0;
                end else if (n_reg <= CW'(1)) begin
                    mode_next   = pcss_pkg::MODE_UNIFORM;
                    uni_next    = first_reg;
                    pcount_next = '0;
                end else begin
                    mode_next   = pcss_pkg::MODE_PALETTE;
                    pcount_next = n_reg;
                end
            end
            pcss_pkg::ST_DONE: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {2'b00, payload, psize, 2'(mode_reg), res_reg};
                end
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pcss_pkg::ST_IDLE;
            mode_reg   <= pcss_pkg::MODE_UNIFORM;
            uni_reg    <= '0;
            pcount_reg <= '0;
            wcount_reg <= '0;
            wbc_reg    <= CW'(1024);
            cpc_reg    <= 1'b0;
            tod_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            uni_reg    <= uni_next;
            pcount_reg <= pcount_next;
            wcount_reg <= wcount_next;
            wbc_reg    <= wbc_next;
            cpc_reg    <= cpc_next;
            tod_reg    <= tod_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        h_reg     <= h_next;
        v_reg     <= v_next;
        first_reg <= first_next;
        mdata_reg <= mdata_next;
    end

endmodule
